// ----- rtl/pff_pkg.sv -----
`timescale 1ns / 1ps
// types, codes and the modulo-255 fold shared by the framer modules
// no dependencies

package pff_pkg;

  localparam logic [8:0] MOD_BASE = 9'h0FF;

  // sequencer steps: header bytes occupy steps 0..2, a payload byte uses step 2
  localparam logic [2:0] STEP_HDR_TYPE  = 3'd0;
  localparam logic [2:0] STEP_LAST_DATA = 3'd2;
  localparam logic [2:0] STEP_CK_LO     = 3'd3;
  localparam logic [2:0] STEP_CK_HI     = 3'd4;

  localparam logic ACT_START   = 1'b0;
  localparam logic ACT_PAYLOAD = 1'b1;

  typedef struct packed {
    logic       action;
    logic [7:0] frame_type;
    logic [7:0] sequence_req;
    logic [7:0] payload_length;
    logic [7:0] payload_byte;
  } item_t;

  typedef struct packed {
    logic [7:0] frame_byte;
    logic       frame_end;
    logic       last;
  } result_t;

  // one queued command: bytes to send starting at first_step, then maybe the checksum
  typedef struct packed {
    logic [2:0][7:0] data;
    logic [2:0]      first_step;
    logic            cksum;
  } cmd_t;

  function automatic logic [7:0] mod_add(input logic [7:0] a, input logic [7:0] b);
    logic [8:0] sum;
    sum = {1'b0, a} + {1'b0, b};
    if (sum >= MOD_BASE) begin
      sum = sum - MOD_BASE;
    end
    return sum[7:0];
  endfunction

endpackage

// ----- rtl/packet_framer_fletcher16.sv -----
`timescale 1ns / 1ps
// Fletcher-16 packet framer, byte serial
// depends on pff_pkg, pff_front, pff_queue, pff_back
//
// item channel: a start transaction (action 0) carries type, sequence and
// length; a payload transaction (action 1) carries one data byte. the frame
// goes out on the result channel one byte per transaction: type, sequence,
// length, payload bytes, then checksum low and high (frame_end on the high
// byte). last marks the final byte caused by one input transaction.
// a payload transaction with no frame open produces nothing; a start
// transaction abandons any open frame.
// the item is written into the queue when it is taken, and the first result
// byte is then registered from the queue head into the output register; a
// stalled output holds it back in the queue.
// the byte sequencer emits one byte per cycle while the receiver does not
// stall; a payload item yields 1 byte (3 when it closes the frame), a
// start item 3 bytes (5 with zero length). a QUEUE_DEPTH command queue
// lets the item side run ahead of the sequencer.
// reset clears the open frame, the sums, the queue and the output valid flag.
// when the receiver stalls the held result stays put, the sequencer waits
// and items are taken until the queue fills.

module packet_framer_fletcher16 import pff_pkg::*; #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    item_valid,
  output logic    item_ready,
  input  item_t   item,
  output logic    result_valid,
  input  logic    result_ready,
  output result_t result
);

  logic push;
  cmd_t push_cmd;
  logic q_full;
  logic pop;
  logic head_valid;
  cmd_t head_cmd;

  pff_front u_front (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .item       (item),
    .q_full     (q_full),
    .push       (push),
    .push_cmd   (push_cmd)
  );

  pff_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_cmd   (push_cmd),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_cmd   (head_cmd)
  );

  pff_back u_back (
    .clk          (clk),
    .rst          (rst),
    .head_valid   (head_valid),
    .head_cmd     (head_cmd),
    .pop          (pop),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

endmodule

// ----- rtl/pff_front.sv -----
`timescale 1ns / 1ps
// front end: accepts items, tracks the open frame and queues byte commands
// depends on pff_pkg

module pff_front import pff_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  item_valid,
  output logic  item_ready,
  input  item_t item,
  input  logic  q_full,
  output logic  push,
  output cmd_t  push_cmd
);

  logic       frame_open;
  logic       frame_open_next;
  logic [7:0] bytes_remaining;
  logic [7:0] bytes_remaining_next;
  logic [7:0] rem_dec;
  logic       accept;

  assign item_ready = !q_full;
  assign accept     = item_valid && item_ready;
  assign rem_dec    = bytes_remaining - 8'd1;

  always_comb begin
    frame_open_next      = frame_open;
    bytes_remaining_next = bytes_remaining;
    push                 = 1'b0;
    push_cmd             = '0;
    if (accept) begin
      if (item.action == ACT_START) begin
        push                = 1'b1;
        push_cmd.data[0]    = item.frame_type;
        push_cmd.data[1]    = item.sequence_req;
        push_cmd.data[2]    = item.payload_length;
        push_cmd.first_step = STEP_HDR_TYPE;
        push_cmd.cksum      = (item.payload_length == 8'd0);
        frame_open_next      = (item.payload_length != 8'd0);
        bytes_remaining_next = item.payload_length;
      end else if (frame_open) begin
        push                = 1'b1;
        push_cmd.data[2]    = item.payload_byte;
        push_cmd.first_step = STEP_LAST_DATA;
        push_cmd.cksum      = (rem_dec == 8'd0);
        frame_open_next      = (rem_dec != 8'd0);
        bytes_remaining_next = rem_dec;
      end
      // payload with no open frame is dropped
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_open      <= 1'b0;
      bytes_remaining <= 8'd0;
    end else begin
      frame_open      <= frame_open_next;
      bytes_remaining <= bytes_remaining_next;
    end
  end

endmodule

// ----- rtl/pff_queue.sv -----
`timescale 1ns / 1ps
// small command queue between front end and byte sequencer
// depends on pff_pkg

module pff_queue import pff_pkg::*; #(
  parameter int DEPTH = 2
) (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t push_cmd,
  output logic full,
  input  logic pop,
  output logic head_valid,
  output cmd_t head_cmd
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  cmd_t             entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign full       = (count == CNT_W'(DEPTH));
  assign head_valid = (count != '0);
  assign head_cmd   = entries[rd_ptr];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

// ----- rtl/pff_back.sv -----
`timescale 1ns / 1ps
// byte sequencer: emits queued bytes, folds the fletcher sums, appends the checksum
// depends on pff_pkg

module pff_back import pff_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    head_valid,
  input  cmd_t    head_cmd,
  output logic    pop,
  output logic    result_valid,
  input  logic    result_ready,
  output result_t result
);

  logic [7:0] sum1;
  logic [7:0] sum2;
  logic [7:0] sum1_next;
  logic [7:0] sum2_next;
  logic [7:0] base1;
  logic [7:0] base2;
  logic       active;
  logic [2:0] step;
  logic [2:0] cur_step;
  logic       advance;
  logic       final_step;
  logic       is_data;
  result_t    emit;

  assign advance  = !result_valid || result_ready;
  assign cur_step = active ? step : head_cmd.first_step;
  assign is_data  = (cur_step <= STEP_LAST_DATA);

  // a header type byte starts the sums again from zero
  assign base1 = (cur_step == STEP_HDR_TYPE) ? 8'd0 : sum1;
  assign base2 = (cur_step == STEP_HDR_TYPE) ? 8'd0 : sum2;

  always_comb begin
    sum1_next  = mod_add(base1, head_cmd.data[cur_step[1:0]]);
    sum2_next  = mod_add(base2, sum1_next);
    final_step = (cur_step == STEP_CK_HI) ||
                 ((cur_step == STEP_LAST_DATA) && !head_cmd.cksum);
    emit.frame_end = (cur_step == STEP_CK_HI);
    emit.last      = final_step;
    case (cur_step)
      STEP_CK_LO: emit.frame_byte = sum1;
      STEP_CK_HI: emit.frame_byte = sum2;
      default:    emit.frame_byte = head_cmd.data[cur_step[1:0]];
    endcase
  end

  assign pop = advance && head_valid && final_step;

  always_ff @(posedge clk) begin
    if (rst) begin
      active       <= 1'b0;
      step         <= STEP_HDR_TYPE;
      sum1         <= 8'd0;
      sum2         <= 8'd0;
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= head_valid;
      if (head_valid) begin
        if (is_data) begin
          sum1 <= sum1_next;
          sum2 <= sum2_next;
        end
        if (final_step) begin
          active <= 1'b0;
        end else begin
          active <= 1'b1;
          step   <= cur_step + 3'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && head_valid) begin
      result <= emit;
    end
  end

endmodule
